// ----- hdl/spcw_pkg.sv -----
package spcw_pkg;

   // configuration register indexes
   localparam logic [3:0] REG_COLOR_MODE    = 4'd0;
   localparam logic [3:0] REG_BITMAP_COLOR  = 4'd1;
   localparam logic [3:0] REG_SCREEN_WIDTH  = 4'd2;
   localparam logic [3:0] REG_SCREEN_HEIGHT = 4'd3;
   localparam logic [3:0] REG_BAND_0        = 4'd4;

   // number of band registers reachable through the configuration port
   localparam int WRITABLE_BANDS = 4;

   typedef enum logic [1:0] {
      MODE_SOURCE = 2'd0,
      MODE_Y_BAND = 2'd1,
      MODE_X_BAND = 2'd2,
      MODE_BITMAP = 2'd3
   } color_mode_type;

   typedef struct packed {
      logic [15:0] bound;  // 0 means unlimited
      logic [31:0] color;
   } band_type;

   localparam logic [7:0]  KEY_ALPHA      = 8'd0;
   localparam logic [16:0] BOUND_UNLIMITED = 17'h10000;
   localparam band_type    BAND_RESET     = '{bound: 16'h0000, color: 32'hFFFF_FFFF};

endpackage

// ----- hdl/spcw_band_select.sv -----
module spcw_band_select #(
   parameter int BAND_COUNT = 4
) (
   input  logic [10:0]             coord,
   input  spcw_pkg::band_type      bands [BAND_COUNT],
   output logic [31:0]             color
);

   // first band in bound order whose bound covers the coordinate,
   // falling back to the largest bound (higher index on ties)
   always_comb begin
      logic        found;
      logic [16:0] pick_bound;
      logic [31:0] pick_color;
      logic [16:0] last_bound;
      logic [31:0] last_color;
      logic [16:0] bound;
      found      = 1'b0;
      pick_bound = '0;
      pick_color = '0;
      last_bound = '0;
      last_color = '0;
      for (int i = 0; i < BAND_COUNT; i++) begin
         bound = (bands[i].bound == 16'h0000) ? spcw_pkg::BOUND_UNLIMITED
                                              : {1'b0, bands[i].bound};
         if (bound >= {6'd0, coord} && (!found || bound < pick_bound)) begin
            found      = 1'b1;
            pick_bound = bound;
            pick_color = bands[i].color;
         end
         if (i == 0 || bound >= last_bound) begin
            last_bound = bound;
            last_color = bands[i].color;
         end
      end
      color = found ? pick_color : last_color;
   end

endmodule

// ----- hdl/sprite_pixel_color_writer.sv -----
// channel | direction | payload, lowest bit first
// req     | in        | tdata: dest_col[11:0], dest_row[23:12], src_color[55:24]
// rsp     | out       | tdata: write_address[19:0], write_color[51:20], zero[55:52]
// csr     | in        | csr_index[3:0], csr_data[47:0]
//
// two register stages: a beat is taken into an input register, checked and
// coloured there, and lands in the result register; one beat per clock
// sustained while rsp is not stalled.
// clipped or keyed beats leave the input register without a result, also while
// rsp is stalled, which otherwise holds both stages; req_tready drops only when both are full.
// reset clears both valid bits and loads the register defaults.
module sprite_pixel_color_writer #(
   parameter int MAX_DIM    = 1024,
   parameter int BAND_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // dest_col, dest_row, src_color
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // write_address, write_color, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [47:0] csr_data
);

   localparam logic [10:0] DIM_CAP = (MAX_DIM > 2047) ? 11'd2047 : 11'(MAX_DIM);

   // configuration registers
   logic [1:0]  color_mode_ff;
   logic [31:0] bitmap_color_ff;
   logic [10:0] screen_width_ff;
   logic [10:0] screen_height_ff;
   spcw_pkg::band_type bands [BAND_COUNT];

   logic csr_write;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff    <= 2'd0;
         bitmap_color_ff  <= 32'hFFFF_FFFF;
         screen_width_ff  <= 11'd256;
         screen_height_ff <= 11'd224;
      end else if (csr_write) begin
         unique case (csr_index)
            spcw_pkg::REG_COLOR_MODE:    color_mode_ff    <= csr_data[1:0];
            spcw_pkg::REG_BITMAP_COLOR:  bitmap_color_ff  <= csr_data[31:0];
            spcw_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_data[10:0];
            spcw_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < BAND_COUNT; i++) begin : g_band
      if (i < spcw_pkg::WRITABLE_BANDS) begin : g_reg
         spcw_pkg::band_type band_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               band_ff <= spcw_pkg::BAND_RESET;
            end else if (csr_write && csr_index == spcw_pkg::REG_BAND_0 + 4'(i)) begin
               band_ff <= csr_data;
            end
         end
         assign bands[i] = band_ff;
      end else begin : g_fixed
         assign bands[i] = spcw_pkg::BAND_RESET;
      end
   end

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [11:0] s1_col_ff;
   logic [11:0] s1_row_ff;
   logic [31:0] s1_color_ff;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_addr_ff;
   logic [31:0] rsp_color_ff;

   logic [10:0] eff_w, eff_h;
   logic        keep;
   logic        s1_move, load_out, req_take;
   logic [10:0] ucol, urow, coord;
   logic [21:0] product;
   logic [19:0] addr;
   logic [31:0] band_color, color;

   assign eff_w = (screen_width_ff  > DIM_CAP) ? DIM_CAP : screen_width_ff;
   assign eff_h = (screen_height_ff > DIM_CAP) ? DIM_CAP : screen_height_ff;
   assign ucol  = s1_col_ff[10:0];
   assign urow  = s1_row_ff[10:0];

   assign keep = !s1_col_ff[11] && !s1_row_ff[11]
              && ucol < eff_w && urow < eff_h
              && s1_color_ff[7:0] != spcw_pkg::KEY_ALPHA;

   assign product = urow * eff_w;
   assign addr    = product[19:0] + {9'd0, ucol};
   assign coord   = (spcw_pkg::color_mode_type'(color_mode_ff) == spcw_pkg::MODE_Y_BAND)
                    ? urow : ucol;

   spcw_band_select #(.BAND_COUNT(BAND_COUNT)) u_band_select (
      .coord (coord),
      .bands (bands),
      .color (band_color)
   );

   always_comb begin
      case (spcw_pkg::color_mode_type'(color_mode_ff))
         spcw_pkg::MODE_SOURCE: color = s1_color_ff;
         spcw_pkg::MODE_Y_BAND,
         spcw_pkg::MODE_X_BAND: color = band_color;
         default:               color = bitmap_color_ff;
      endcase
   end

   assign load_out   = s1_valid_ff && keep && (!rsp_valid_ff || rsp_tready);
   assign s1_move    = s1_valid_ff && (!keep || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_col_ff   <= req_tdata[11:0];
         s1_row_ff   <= req_tdata[23:12];
         s1_color_ff <= req_tdata[55:24];
      end
      if (load_out) begin
         rsp_addr_ff  <= addr;
         rsp_color_ff <= color;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_color_ff, rsp_addr_ff};

   // both stages empty straight after reset
   assert property (@(posedge clock) reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   // a held beat in the input stage is never lost
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff)
      else $error("input stage beat dropped while stalled");

   // a result only ever comes from a beat that passed the clip and key checks
   assert property (@(posedge clock) disable iff (reset)
      load_out |-> keep && s1_valid_ff)
      else $error("result loaded from a rejected beat");

   // source colour results never carry the key alpha
   assert property (@(posedge clock) disable iff (reset)
      load_out && spcw_pkg::color_mode_type'(color_mode_ff) == spcw_pkg::MODE_SOURCE
      |=> rsp_tdata[27:20] != spcw_pkg::KEY_ALPHA)
      else $error("keyed pixel reached the output");

   // the input stage only waits on a full, stalled output
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !req_tready |-> rsp_valid_ff && !rsp_tready && keep)
      else $error("input stalled without back-pressure");

endmodule

// ----- test/sprite_pixel_color_writer_tb.sv -----
module sprite_pixel_color_writer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_MAX = 1024;
   localparam int BANDS      = 4;

   typedef struct {
      logic [19:0] addr;
      logic [31:0] color;
   } pixel_write_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // dest_col, dest_row, src_color
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // write_address, write_color, zero pad
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [47:0] csr_data;

   // shadow copy of the register file
   spcw_pkg::color_mode_type cfg_mode;
   logic [31:0]              cfg_bitmap;
   logic [10:0]              cfg_width;
   logic [10:0]              cfg_height;
   spcw_pkg::band_type       cfg_band [BANDS];

   pixel_write_type pending_writes [$];
   pixel_write_type expected_write;
   int              errors;

   // sender burst shaping
   int max_gap;
   int burst_left;

   // receiver stall pattern
   int stall_hold;
   int rx_mode;
   int rx_left;
   int rx_phase;

   sprite_pixel_color_writer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] band_lookup(input int coord);
      int pick;
      int pick_bound;
      int last_idx;
      int last_bound;
      int b;
      pick       = -1;
      pick_bound = 0;
      last_idx   = 0;
      last_bound = 0;
      for (int i = 0; i < BANDS; i++) begin
         b = (cfg_band[i].bound == 16'd0) ? int'(spcw_pkg::BOUND_UNLIMITED)
                                          : int'(cfg_band[i].bound);
         if (b >= coord && (pick < 0 || b < pick_bound)) begin
            pick       = i;
            pick_bound = b;
         end
         // past every band: largest bound, ties to the higher index
         if (i == 0 || b >= last_bound) begin
            last_idx   = i;
            last_bound = b;
         end
      end
      if (pick < 0) pick = last_idx;
      return cfg_band[2'(pick)].color;
   endfunction

   function automatic bit predict_write(input logic signed [11:0] col,
                                        input logic signed [11:0] row,
                                        input logic [31:0] src,
                                        output pixel_write_type wr);
      int w;
      int h;
      int c;
      int r;
      w = (cfg_width > SCREEN_MAX) ? SCREEN_MAX : int'(cfg_width);
      h = (cfg_height > SCREEN_MAX) ? SCREEN_MAX : int'(cfg_height);
      c = int'(col);
      r = int'(row);
      wr.addr  = '0;
      wr.color = '0;
      if (c < 0 || r < 0 || c >= w || r >= h) return 1'b0;
      if (src[7:0] == spcw_pkg::KEY_ALPHA) return 1'b0;
      case (cfg_mode)
         spcw_pkg::MODE_SOURCE: wr.color = src;
         spcw_pkg::MODE_Y_BAND: wr.color = band_lookup(r);
         spcw_pkg::MODE_X_BAND: wr.color = band_lookup(c);
         default:               wr.color = cfg_bitmap;
      endcase
      wr.addr = 20'(c + r * w);
      return 1'b1;
   endfunction

   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                             input logic [31:0] src);
      pixel_write_type wr;
      int              gap;
      if (max_gap > 0) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, max_gap);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {src, row, col};
      do @(posedge clock); while (!req_tready);
      if (predict_write(col, row, src, wr)) pending_writes.insert(pending_writes.size(), wr);
   endtask

   task automatic wait_drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      // dropped beats may still sit in the pipe
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] idx, input logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         spcw_pkg::REG_COLOR_MODE:    cfg_mode   = spcw_pkg::color_mode_type'(val[1:0]);
         spcw_pkg::REG_BITMAP_COLOR:  cfg_bitmap = val[31:0];
         spcw_pkg::REG_SCREEN_WIDTH:  cfg_width  = val[10:0];
         spcw_pkg::REG_SCREEN_HEIGHT: cfg_height = val[10:0];
         default: begin
            if (idx >= spcw_pkg::REG_BAND_0
                && idx < spcw_pkg::REG_BAND_0 + spcw_pkg::WRITABLE_BANDS)
               cfg_band[2'(idx - spcw_pkg::REG_BAND_0)] = spcw_pkg::band_type'(val);
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_pixel(input int onscreen_pct);
      logic [11:0] col;
      logic [11:0] row;
      logic [31:0] src;
      int          w;
      int          h;
      w = (cfg_width > SCREEN_MAX) ? SCREEN_MAX : int'(cfg_width);
      h = (cfg_height > SCREEN_MAX) ? SCREEN_MAX : int'(cfg_height);
      if (w > 0 && h > 0 && $urandom_range(99) < onscreen_pct) begin
         col = 12'($urandom_range(0, w - 1));
         row = 12'($urandom_range(0, h - 1));
         // hug the right and bottom clip edges now and then
         if ($urandom_range(7) == 0) col = 12'(w - $urandom_range(0, 1));
         if ($urandom_range(7) == 0) row = 12'(h - $urandom_range(0, 1));
      end else begin
         col = 12'($urandom);
         row = 12'($urandom);
      end
      src = $urandom;
      if ($urandom_range(15) == 0) src[7:0] = spcw_pkg::KEY_ALPHA;
      send_pixel(col, row, src);
   endtask

   task automatic randomise_registers();
      logic [15:0] bound;
      logic [15:0] prev_bound;
      prev_bound = 16'd0;
      csr_write(spcw_pkg::REG_COLOR_MODE, 48'($urandom));
      csr_write(spcw_pkg::REG_BITMAP_COLOR, {16'($urandom), 32'($urandom)});
      case ($urandom_range(9))
         0:       csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'd1);
         1:       csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'd1024);
         2:       csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'($urandom_range(1025, 2047)));
         default: csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'($urandom_range(1, 1024)));
      endcase
      case ($urandom_range(9))
         0:       csr_write(spcw_pkg::REG_SCREEN_HEIGHT, 48'd1);
         1:       csr_write(spcw_pkg::REG_SCREEN_HEIGHT, 48'd1024);
         2:       csr_write(spcw_pkg::REG_SCREEN_HEIGHT, 48'($urandom_range(1025, 2047)));
         default: csr_write(spcw_pkg::REG_SCREEN_HEIGHT, 48'($urandom_range(1, 1024)));
      endcase
      for (int i = 0; i < spcw_pkg::WRITABLE_BANDS; i++) begin
         case ($urandom_range(5))
            0:       bound = 16'd0;
            1:       bound = 16'($urandom);
            2:       bound = prev_bound;
            default: bound = 16'($urandom_range(1, 1100));
         endcase
         prev_bound = bound;
         csr_write(4'(spcw_pkg::REG_BAND_0 + i), {bound, 32'($urandom)});
      end
      // indexes past the last band are ignored
      if ($urandom_range(3) == 0)
         csr_write(4'($urandom_range(spcw_pkg::REG_BAND_0 + spcw_pkg::WRITABLE_BANDS, 15)),
                   {16'($urandom), 32'($urandom)});
   endtask

   task automatic test_clipping_and_key();
      wait_drain();
      send_pixel(12'd0, 12'd0, 32'h1122_3301);
      send_pixel(12'd255, 12'd223, 32'hFFFF_FFFF);
      send_pixel(12'd256, 12'd0, 32'h5555_5555);
      send_pixel(12'd0, 12'd224, 32'h5555_5555);
      send_pixel(12'hFFF, 12'd5, 32'h6666_6666);
      send_pixel(12'd5, 12'hFFF, 32'h6666_6666);
      send_pixel(12'h800, 12'h800, 32'h7777_7777);
      send_pixel(12'h7FF, 12'h7FF, 32'h8888_8888);
      send_pixel(12'd10, 12'd10, 32'hAABB_CC00);
      send_pixel(12'd10, 12'd11, 32'h0000_0001);
      wait_drain();
   endtask

   task automatic test_band_selection();
      wait_drain();
      csr_write(spcw_pkg::REG_COLOR_MODE, 48'(spcw_pkg::MODE_Y_BAND));
      // bands straight out of reset: unlimited, white
      send_pixel(12'd3, 12'd100, 32'h0102_0304);
      wait_drain();
      csr_write(spcw_pkg::REG_BAND_0,            {16'd10, 32'hA0A0_A001});
      csr_write(4'(spcw_pkg::REG_BAND_0 + 1),    {16'd10, 32'hB0B0_B002});
      csr_write(4'(spcw_pkg::REG_BAND_0 + 2),    {16'd0,  32'hC0C0_C003});
      csr_write(4'(spcw_pkg::REG_BAND_0 + 3),    {16'd50, 32'hD0D0_D004});
      send_pixel(12'd0, 12'd5, 32'hFFFF_FF01);
      send_pixel(12'd0, 12'd10, 32'hFFFF_FF01);
      send_pixel(12'd0, 12'd11, 32'hFFFF_FF01);
      send_pixel(12'd0, 12'd51, 32'hFFFF_FF01);
      wait_drain();
      // every bound below the coordinate, equal largest bounds
      csr_write(spcw_pkg::REG_BAND_0,            {16'd30, 32'h1111_1111});
      csr_write(4'(spcw_pkg::REG_BAND_0 + 1),    {16'd30, 32'h2222_2222});
      csr_write(4'(spcw_pkg::REG_BAND_0 + 2),    {16'd5,  32'h3333_3333});
      csr_write(4'(spcw_pkg::REG_BAND_0 + 3),    {16'd5,  32'h4444_4444});
      send_pixel(12'd0, 12'd40, 32'hFFFF_FF01);
      wait_drain();
      csr_write(spcw_pkg::REG_COLOR_MODE, 48'(spcw_pkg::MODE_X_BAND));
      send_pixel(12'd4, 12'd200, 32'hFFFF_FF01);
      send_pixel(12'd200, 12'd4, 32'hFFFF_FF01);
      wait_drain();
      csr_write(spcw_pkg::REG_BITMAP_COLOR, {16'hFFFF, 32'h1357_9BDF});
      csr_write(spcw_pkg::REG_COLOR_MODE, 48'(spcw_pkg::MODE_BITMAP));
      send_pixel(12'd17, 12'd19, 32'h0000_00FF);
      wait_drain();
   endtask

   task automatic test_screen_limits();
      wait_drain();
      csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'd2047);
      csr_write(spcw_pkg::REG_SCREEN_HEIGHT, 48'd2047);
      send_pixel(12'd1023, 12'd1023, 32'h0A0B_0C0D);
      send_pixel(12'd1024, 12'd0, 32'h0A0B_0C0D);
      wait_drain();
      csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'd0);
      send_pixel(12'd0, 12'd0, 32'h0A0B_0C0D);
      wait_drain();
      csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'd256);
      csr_write(4'hF, 48'hFFFF_FFFF_FFFF);
      send_pixel(12'd1, 12'd2, 32'h0A0B_0C0D);
      wait_drain();
   endtask

   task automatic test_random_blits();
      for (int phase = 0; phase < 12; phase++) begin
         wait_drain();
         randomise_registers();
         max_gap    = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = 0;
         repeat (170) send_random_pixel(80);
      end
      wait_drain();
   endtask

   task automatic test_backpressure();
      wait_drain();
      csr_write(spcw_pkg::REG_COLOR_MODE, 48'(spcw_pkg::MODE_SOURCE));
      csr_write(spcw_pkg::REG_SCREEN_WIDTH, 48'd256);
      csr_write(spcw_pkg::REG_SCREEN_HEIGHT, 48'd224);
      max_gap    = 0;
      stall_hold = 400;
      repeat (80) send_random_pixel(100);
      wait_drain();
      max_gap    = 4;
      burst_left = 0;
      stall_hold = 150;
      repeat (40) send_random_pixel(90);
      wait_drain();
   endtask

   // receiver: changing stall patterns, with a long hold on request
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(3);
            rx_left = $urandom_range(5, 60);
         end
         rx_left--;
         rx_phase++;
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(1));
            2:       rsp_tready <= (rx_phase % 4) != 3;
            default: rsp_tready <= $urandom_range(3) == 0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $error("result beat with nothing expected: addr %h color %h",
                   rsp_tdata[19:0], rsp_tdata[51:20]);
            errors++;
         end else begin
            expected_write = pending_writes.pop_front();
            if (rsp_tdata[19:0] !== expected_write.addr) begin
               $error("write_address expected %h actual %h",
                      expected_write.addr, rsp_tdata[19:0]);
               errors++;
            end
            if (rsp_tdata[51:20] !== expected_write.color) begin
               $error("write_color expected %h actual %h",
                      expected_write.color, rsp_tdata[51:20]);
               errors++;
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("sprite_pixel_color_writer test failed");
      $finish;
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      errors     = 0;
      max_gap    = 0;
      burst_left = 0;
      stall_hold = 0;
      rx_mode    = 0;
      rx_left    = 0;
      rx_phase   = 0;
      cfg_mode   = spcw_pkg::MODE_SOURCE;
      cfg_bitmap = 32'hFFFF_FFFF;
      cfg_width  = 11'd256;
      cfg_height = 11'd224;
      for (int i = 0; i < BANDS; i++) cfg_band[i] = spcw_pkg::BAND_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_clipping_and_key();
      test_band_selection();
      test_screen_limits();
      test_random_blits();
      test_backpressure();

      wait_drain();
      if (pending_writes.size() != 0) begin
         $error("%0d expected results never arrived", pending_writes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("sprite_pixel_color_writer test passed");
      end else begin
         $display("sprite_pixel_color_writer test failed");
      end
      $finish;
   end

endmodule
